// ----- design/tsosc_pkg.sv -----
package tsosc_pkg;

   // field widths
   localparam int BPM_W   = 10;
   localparam int DIV_W   = 7;
   localparam int MULT_W  = 4;
   localparam int QUANT_W = 6;
   localparam int Q16_W   = 17;
   localparam int FLAGS_W = 3;
   localparam int MODE_W  = 2;
   localparam int BS_W    = 14;
   localparam int RAW_W   = 16;

   // datapath widths
   localparam int FRAC_W   = 32;
   localparam int Q16_FRAC = 16;
   localparam int BM_W     = BPM_W + MULT_W;
   localparam int NUM_W    = BM_W + BS_W;
   localparam int DVD_W    = NUM_W + FRAC_W;
   localparam int SHP_W    = FRAC_W + 1;
   localparam int QUO_W    = SHP_W;
   localparam int CNT_W    = $clog2(DVD_W + 1);
   localparam int QPROD_W  = SHP_W + QUANT_W;
   localparam int MPROD_W  = Q16_W + SHP_W;
   localparam int MAG_W    = MPROD_W - FRAC_W;

   // csr port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // constants
   localparam int SAMPLE_RATE_DEF = 44100;
   localparam int SEC_PER_MIN     = 60;
   localparam int FRAME_DEN       = 3600;
   localparam int DIV_MAX         = 2**DIV_W - 1;
   localparam logic [QUANT_W-1:0] QUANT_OFF = QUANT_W'(40);
   localparam logic [Q16_W-1:0]   ONE_Q16   = Q16_W'(65536);
   localparam logic [SHP_W-1:0]   ONE_Q32   = SHP_W'(1) << FRAC_W;

   localparam logic [CNT_W-1:0] ITERS_ADV   = CNT_W'(DVD_W);
   localparam logic [CNT_W-1:0] ITERS_QUANT = CNT_W'(QUANT_W + FRAC_W);

   // mode_flags bit positions
   localparam int FLAG_LOOP    = 0;
   localparam int FLAG_BOUNCE  = 1;
   localparam int FLAG_OFFLINE = 2;

   function automatic int den_base_w(input longint sr);
      longint top_val;
      top_val = longint'(DIV_MAX) * longint'(SEC_PER_MIN) * sr + 64'sd1;
      return $clog2(top_val);
   endfunction

   localparam int DEN_W_DEF = den_base_w(longint'(SAMPLE_RATE_DEF)) + 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_AUDIO = 2'd0,
      MODE_FRAME = 2'd1,
      MODE_RESET = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_TEMPO_BPM       = 3'd0,
      REG_BEAT_DIVIDER    = 3'd1,
      REG_BEAT_MULTIPLIER = 3'd2,
      REG_QUANT_STEPS     = 3'd3,
      REG_START_PHASE     = 3'd4,
      REG_LOW_VALUE       = 3'd5,
      REG_HIGH_VALUE      = 3'd6,
      REG_MODE_FLAGS      = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [BPM_W-1:0]   tempo_bpm;
      logic [DIV_W-1:0]   beat_divider;
      logic [MULT_W-1:0]  beat_multiplier;
      logic [QUANT_W-1:0] quant_steps;
      logic [Q16_W-1:0]   start_phase;
      logic [Q16_W-1:0]   low_value;
      logic [Q16_W-1:0]   high_value;
      logic [FLAGS_W-1:0] mode_flags;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      tempo_bpm:       BPM_W'(120),
      beat_divider:    DIV_W'(1),
      beat_multiplier: MULT_W'(1),
      quant_steps:     QUANT_OFF,
      start_phase:     '0,
      low_value:       '0,
      high_value:      ONE_Q16,
      mode_flags:      FLAGS_W'(1)
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PREP,
      ST_NUM,
      ST_ASTART,
      ST_AWAIT,
      ST_FOLD,
      ST_SHAPE,
      ST_QSTART,
      ST_QWAIT,
      ST_MAP,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic num;
      logic div_start;
      logic div_quant;
      logic load_start;
      logic phase_step;
      logic fold;
      logic qmul;
      logic shape_x;
      logic shape_zero;
      logic shape_quo;
      logic map_mul;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic advance;
      logic reset_mode;
      logic quant_on;
      logic quant_zero;
      logic div_done;
      logic out_busy;
   } dp_sts_type;

endpackage

// ----- design/tsosc_regs.sv -----
module tsosc_regs import tsosc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic                  start_load
);

   cfg_type     cfg_ff, cfg_in;
   logic        start_load_ff, start_load_in;
   logic        wr;
   csr_idx_type idx;

   assign wr     = psel & penable & pwrite;
   assign idx    = csr_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign pready = 1'b1;

   always_comb begin
      cfg_in        = cfg_ff;
      start_load_in = 1'b0;
      if (wr) begin
         unique case (idx)
            REG_TEMPO_BPM:       cfg_in.tempo_bpm       = pwdata[BPM_W-1:0];
            REG_BEAT_DIVIDER:    cfg_in.beat_divider    = pwdata[DIV_W-1:0];
            REG_BEAT_MULTIPLIER: cfg_in.beat_multiplier = pwdata[MULT_W-1:0];
            REG_QUANT_STEPS:     cfg_in.quant_steps     = pwdata[QUANT_W-1:0];
            REG_START_PHASE: begin
               cfg_in.start_phase = pwdata[Q16_W-1:0];
               start_load_in      = ~cfg_ff.mode_flags[FLAG_LOOP];
            end
            REG_LOW_VALUE:       cfg_in.low_value       = pwdata[Q16_W-1:0];
            REG_HIGH_VALUE:      cfg_in.high_value      = pwdata[Q16_W-1:0];
            REG_MODE_FLAGS: begin
               cfg_in.mode_flags = pwdata[FLAGS_W-1:0];
               start_load_in     = ~pwdata[FLAG_LOOP];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         start_load_ff <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         start_load_ff <= start_load_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_TEMPO_BPM:       prdata = CSR_DATA_W'(cfg_ff.tempo_bpm);
         REG_BEAT_DIVIDER:    prdata = CSR_DATA_W'(cfg_ff.beat_divider);
         REG_BEAT_MULTIPLIER: prdata = CSR_DATA_W'(cfg_ff.beat_multiplier);
         REG_QUANT_STEPS:     prdata = CSR_DATA_W'(cfg_ff.quant_steps);
         REG_START_PHASE:     prdata = CSR_DATA_W'(cfg_ff.start_phase);
         REG_LOW_VALUE:       prdata = CSR_DATA_W'(cfg_ff.low_value);
         REG_HIGH_VALUE:      prdata = CSR_DATA_W'(cfg_ff.high_value);
         REG_MODE_FLAGS:      prdata = CSR_DATA_W'(cfg_ff.mode_flags);
         default:             prdata = '0;
      endcase
   end

   assign cfg        = cfg_ff;
   assign start_load = start_load_ff;

endmodule

// ----- design/tsosc_div.sv -----
module tsosc_div import tsosc_pkg::*; #(
   parameter int DEN_W = DEN_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   input  logic [CNT_W-1:0] iters,
   output logic [QUO_W-1:0] quotient,
   output logic             done
);

   // restoring divider, one quotient bit per cycle, msb first
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = iters;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ----- design/tsosc_datapath.sv -----
module tsosc_datapath import tsosc_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_sts_type        sts,
   input  cfg_type           cfg,
   input  logic              start_load,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [BS_W-1:0]   req_buffer_size,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [Q16_W-1:0]  rsp_mapped_value,
   output logic [RAW_W-1:0]  rsp_raw_phase
);

   localparam longint SCALE_AUDIO = longint'(SEC_PER_MIN) * longint'(SAMPLE_RATE);
   localparam int     SCALE_W     = $clog2(SCALE_AUDIO + 64'sd1);
   localparam int     DENB_W      = den_base_w(longint'(SAMPLE_RATE));
   localparam int     DEN_W       = DENB_W + 1;

   mode_type             mode_ff, mode_in;
   logic [BS_W-1:0]      bs_ff, bs_in;
   logic [FRAC_W-1:0]    phase_ff, phase_in;
   logic [SHP_W-1:0]     shaped_ff, shaped_in;
   logic [BM_W-1:0]      bm_ff;
   logic [DENB_W-1:0]    denb_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [SHP_W-1:0]     x_ff;
   logic [QPROD_W-1:0]   qprod_ff;
   logic [MPROD_W-1:0]   mprod_ff;
   logic                 down_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [Q16_W-1:0]     mapped_ff;
   logic [RAW_W-1:0]     raw_ff;

   logic                 audio;
   logic [DIV_W-1:0]     div_eff;
   logic [SCALE_W-1:0]   scale;
   logic [DIV_W+SCALE_W-1:0] denb_prod;
   logic [BM_W-1:0]      bm_prod;
   logic [BS_W-1:0]      bs_sel;
   logic [NUM_W-1:0]     num_prod;
   logic [Q16_W-1:0]     start_sat;
   logic [SHP_W-1:0]     start_q;
   logic [SHP_W:0]       fold_full;
   logic [SHP_W-1:0]     x_shape;
   logic [SHP_W:0]       x_sum;
   logic [SHP_W:0]       x_wrap;
   logic [QPROD_W-1:0]   qprod;
   logic [QUANT_W-1:0]   quant_k;
   logic [DVD_W-1:0]     div_dividend;
   logic [DEN_W-1:0]     div_divisor;
   logic [CNT_W-1:0]     div_iters;
   logic [QUO_W-1:0]     quo;
   logic                 div_done;
   logic                 map_up;
   logic [Q16_W-1:0]     map_d;
   logic [MPROD_W-1:0]   mprod;
   logic [MAG_W-1:0]     mag;
   logic [MAG_W-1:0]     mag_ceil;
   logic [Q16_W-1:0]     mapped;

   assign audio = (mode_ff == MODE_AUDIO);

   // increment operands
   assign div_eff   = (cfg.beat_divider == '0) ? DIV_W'(1) : cfg.beat_divider;
   assign scale     = audio ? SCALE_W'(SCALE_AUDIO) : SCALE_W'(FRAME_DEN);
   assign denb_prod = div_eff * scale;
   assign bm_prod   = cfg.tempo_bpm * cfg.beat_multiplier;
   assign bs_sel    = audio ? bs_ff : BS_W'(1);
   assign num_prod  = bm_ff * bs_sel;

   // start phase in q32, saturated at one
   assign start_sat = (cfg.start_phase > ONE_Q16) ? ONE_Q16 : cfg.start_phase;
   assign start_q   = {start_sat, {Q16_FRAC{1'b0}}};

   // triangle fold and offset
   assign fold_full = {2'b10, {FRAC_W{1'b0}}} - {1'b0, phase_ff, 1'b0};
   always_comb begin
      if (!cfg.mode_flags[FLAG_BOUNCE]) begin
         x_shape = {1'b0, phase_ff};
      end else if (!phase_ff[FRAC_W-1]) begin
         x_shape = {phase_ff, 1'b0};
      end else begin
         x_shape = fold_full[SHP_W-1:0];
      end
   end
   assign x_sum  = {1'b0, x_shape} + {1'b0, start_q};
   assign x_wrap = (x_sum >= {1'b0, ONE_Q32}) ? x_sum - {1'b0, ONE_Q32} : x_sum;

   assign qprod   = x_ff * cfg.quant_steps;
   assign quant_k = qprod_ff[FRAC_W +: QUANT_W];

   // shared divider operands
   assign div_dividend = cmd.div_quant ? {quant_k, {(DVD_W-QUANT_W){1'b0}}}
                                       : {num_ff, {FRAC_W{1'b0}}};
   assign div_divisor  = cmd.div_quant ? DEN_W'(cfg.quant_steps) : den_ff;
   assign div_iters    = cmd.div_quant ? ITERS_QUANT : ITERS_ADV;

   tsosc_div #(
      .DEN_W(DEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .iters    (div_iters),
      .quotient (quo),
      .done     (div_done)
   );

   // output mapping
   assign map_up   = cfg.high_value >= cfg.low_value;
   assign map_d    = map_up ? cfg.high_value - cfg.low_value : cfg.low_value - cfg.high_value;
   assign mprod    = map_d * shaped_ff;
   assign mag      = mprod_ff[FRAC_W +: MAG_W];
   assign mag_ceil = mag + MAG_W'(|mprod_ff[FRAC_W-1:0]);
   always_comb begin
      if (down_ff) begin
         mapped = cfg.low_value - mag_ceil[Q16_W-1:0];
      end else begin
         mapped = cfg.low_value + mag[Q16_W-1:0];
      end
   end

   always_comb begin
      mode_in = mode_ff;
      bs_in   = bs_ff;
      if (cmd.capture) begin
         mode_in = mode_type'(req_mode);
         bs_in   = req_buffer_size;
      end
   end

   always_comb begin
      priority if (cmd.load_start) begin
         phase_in = start_q[FRAC_W-1:0];
      end else if (cmd.phase_step) begin
         phase_in = phase_ff + quo[FRAC_W-1:0];
      end else begin
         phase_in = phase_ff;
      end
   end

   always_comb begin
      priority if (start_load || cmd.load_start) begin
         shaped_in = start_q;
      end else if (cmd.shape_x) begin
         shaped_in = x_ff;
      end else if (cmd.shape_zero) begin
         shaped_in = '0;
      end else if (cmd.shape_quo) begin
         shaped_in = quo;
      end else begin
         shaped_in = shaped_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         shaped_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         shaped_ff    <= shaped_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      bs_ff   <= bs_in;
      if (cmd.prep) begin
         bm_ff   <= bm_prod;
         denb_ff <= denb_prod[DENB_W-1:0];
      end
      if (cmd.num) begin
         num_ff <= num_prod;
         den_ff <= cfg.mode_flags[FLAG_BOUNCE] ? {denb_ff, 1'b0} : {1'b0, denb_ff};
      end
      if (cmd.fold) begin
         x_ff <= x_wrap[SHP_W-1:0];
      end
      if (cmd.qmul) begin
         qprod_ff <= qprod;
      end
      if (cmd.map_mul) begin
         mprod_ff <= mprod;
         down_ff  <= ~map_up;
      end
      if (cmd.out_load) begin
         mapped_ff <= mapped;
         raw_ff    <= phase_ff[FRAC_W-1 -: RAW_W];
      end
   end

   always_comb begin
      sts            = '0;
      sts.advance    = (audio && cfg.mode_flags[FLAG_LOOP] && !cfg.mode_flags[FLAG_OFFLINE])
                    || (mode_ff == MODE_FRAME && cfg.mode_flags[FLAG_OFFLINE]);
      sts.reset_mode = (mode_ff == MODE_RESET);
      sts.quant_on   = (cfg.quant_steps != QUANT_OFF);
      sts.quant_zero = (cfg.quant_steps == '0);
      sts.div_done   = div_done;
      sts.out_busy   = out_valid_ff & rsp_stall;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_mapped_value = mapped_ff;
   assign rsp_raw_phase    = raw_ff;

`ifndef SYNTHESIS
   a_shaped_bound: assert property (@(posedge clock) disable iff (reset)
      shaped_ff <= ONE_Q32)
      else $error("shaped phase above one");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("result appeared without a load");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(cmd.phase_step) && !$past(cmd.load_start))
      |-> $stable(phase_ff))
      else $error("phase moved without a step or reload");
`endif

endmodule

// ----- design/tsosc_ctrl.sv -----
module tsosc_ctrl import tsosc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (sts.advance) begin
               state_in = ST_PREP;
            end else if (sts.reset_mode) begin
               cmd.load_start = 1'b1;
               state_in       = ST_MAP;
            end else begin
               state_in = ST_MAP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            cmd.num  = 1'b1;
            state_in = ST_ASTART;
         end
         ST_ASTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_AWAIT;
         end
         ST_AWAIT: begin
            if (sts.div_done) begin
               cmd.phase_step = 1'b1;
               state_in       = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ST_SHAPE;
         end
         ST_SHAPE: begin
            priority if (!sts.quant_on) begin
               cmd.shape_x = 1'b1;
               state_in    = ST_MAP;
            end else if (sts.quant_zero) begin
               cmd.shape_zero = 1'b1;
               state_in       = ST_MAP;
            end else begin
               cmd.qmul = 1'b1;
               state_in = ST_QSTART;
            end
         end
         ST_QSTART: begin
            cmd.div_start = 1'b1;
            cmd.div_quant = 1'b1;
            state_in      = ST_QWAIT;
         end
         ST_QWAIT: begin
            if (sts.div_done) begin
               cmd.shape_quo = 1'b1;
               state_in      = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map_mul = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == ST_AWAIT || state_ff == ST_QWAIT))
      else $error("divider finished outside a wait state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      sts.out_busy |-> !cmd.out_load)
      else $error("result register overwritten while held");

   a_capture_decide: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_DECIDE)
      else $error("captured request not decoded");
`endif

endmodule

// ----- design/tempo_synced_phase_oscillator_core.sv -----
// Tempo-synced phase oscillator (control-rate LFO). Each request is one tick: an audio buffer
// tick advances the Q32 phase by tempo*mult*buffer_size/(60*div*SAMPLE_RATE) cycles when loop
// is on and offline is off, a frame tick advances it by tempo*mult/(3600*div) when offline is
// on, both halved with bounce on; a reset tick reloads the phase from start_phase and a read
// tick changes nothing; every tick gives exactly one response with the shaped phase mapped
// from low_value to high_value (Q16) and the top 16 bits of the accumulator. One request is
// in work at a time. An advancing tick spends almost all of its time in the shared restoring
// divider, which yields one quotient bit per cycle while busy (60 bits for the increment, 38
// for the quantiser when quant_steps is neither 40 nor 0). The response sits in an output
// register, so a new request is taken while the previous response is still stalled, and the
// design only waits at the end if the output register is still full. Configuration is to be
// written over the APB port only while the block is idle; the block itself does not enforce
// this. pready is always high and there is no clearing pass after reset.
module tempo_synced_phase_oscillator_core import tsosc_pkg::*; #(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [MODE_W-1:0]     req_mode,
   input  logic [BS_W-1:0]       req_buffer_size,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [Q16_W-1:0]      rsp_mapped_value,
   output logic [RAW_W-1:0]      rsp_raw_phase,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   logic       start_load;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // register file; a start_phase or mode_flags write with loop off reloads the shaped phase
   tsosc_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .start_load (start_load)
   );

   // sequencer: decode tick, run increment division, fold, quantise, map, hand off
   tsosc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // accumulator, multipliers, shared divider and output register
   tsosc_datapath #(
      .SAMPLE_RATE(SAMPLE_RATE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg),
      .start_load       (start_load),
      .req_mode         (req_mode),
      .req_buffer_size  (req_buffer_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped_value (rsp_mapped_value),
      .rsp_raw_phase    (rsp_raw_phase)
   );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import tsosc_pkg::*;

   // one tick request as it waits for the driver
   typedef struct {
      mode_type        mode;
      logic [BS_W-1:0] buffer_size;
   } tick_req_type;

   // one oscillator response
   typedef struct packed {
      logic [Q16_W-1:0] mapped_value;
      logic [RAW_W-1:0] raw_phase;
   } osc_out_type;

   localparam int        RANDOM_PHASES = 10;
   localparam int        PHASE_TICKS   = 175;
   localparam int        BURST_LEN     = 64;    // requests per stretch of idling or none
   localparam int        MAX_WAIT      = 14;
   localparam int        SETTLE_CYCLES = 150;   // beyond the slowest quantised tick
   localparam bit [63:0] UNIT_Q32      = 64'd1 << FRAC_W;
   localparam int        BS_TOP        = 2**BS_W - 1;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode        = '0;
   logic [BS_W-1:0]       req_buffer_size = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [Q16_W-1:0]      rsp_mapped_value;
   logic [RAW_W-1:0]      rsp_raw_phase;
   logic                  psel            = 1'b0;
   logic                  penable         = 1'b0;
   logic                  pwrite          = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr           = '0;
   logic [CSR_DATA_W-1:0] pwdata          = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor copy of the registers and the oscillator state
   cfg_type           osc_cfg;
   logic [FRAC_W-1:0] osc_phase;
   logic [SHP_W-1:0]  osc_shape;

   tick_req_type queued_ticks[$];      // ticks not yet offered to the block
   osc_out_type  awaited_outputs[$];   // predicted responses, oldest first
   bit           mismatch_seen = 1'b0;
   int           ticks_sent    = 0;
   int           outputs_seen  = 0;
   int           req_gap       = 0;
   int           rsp_hold      = 0;

   tempo_synced_phase_oscillator_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // idle cycles before a request or a response: stretches of none, then up to MAX_WAIT each
   function automatic int draw_wait(input int n);
      if ((n / BURST_LEN) % 3 == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // start phase as Q32, saturated at one
   function automatic bit [63:0] start_q32();
      bit [63:0] s;
      s = (osc_cfg.start_phase > ONE_Q16) ? 64'(ONE_Q16) : 64'(osc_cfg.start_phase);
      return s << Q16_FRAC;
   endfunction

   // register write as the block sees it; loop off pins the shape to the start phase
   function automatic void apply_register(input csr_idx_type idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_TEMPO_BPM:       osc_cfg.tempo_bpm       = data[BPM_W-1:0];
         REG_BEAT_DIVIDER:    osc_cfg.beat_divider    = data[DIV_W-1:0];
         REG_BEAT_MULTIPLIER: osc_cfg.beat_multiplier = data[MULT_W-1:0];
         REG_QUANT_STEPS:     osc_cfg.quant_steps     = data[QUANT_W-1:0];
         REG_START_PHASE: begin
            osc_cfg.start_phase = data[Q16_W-1:0];
            if (!osc_cfg.mode_flags[FLAG_LOOP])
               osc_shape = SHP_W'(start_q32());
         end
         REG_LOW_VALUE:       osc_cfg.low_value       = data[Q16_W-1:0];
         REG_HIGH_VALUE:      osc_cfg.high_value      = data[Q16_W-1:0];
         REG_MODE_FLAGS: begin
            osc_cfg.mode_flags = data[FLAGS_W-1:0];
            if (!osc_cfg.mode_flags[FLAG_LOOP])
               osc_shape = SHP_W'(start_q32());
         end
      endcase
   endfunction

   // advance the oscillator by one tick and work out the response it gives
   function automatic osc_out_type predict_tick(input mode_type mode,
                                                input logic [BS_W-1:0] bs);
      bit [63:0]   div, num, den, inc, x, k, lo, hi, mapped;
      bit          bounce, step;
      osc_out_type res;
      bounce = osc_cfg.mode_flags[FLAG_BOUNCE];
      div    = (osc_cfg.beat_divider == 0) ? 64'd1 : 64'(osc_cfg.beat_divider);
      num    = 64'(osc_cfg.tempo_bpm) * 64'(osc_cfg.beat_multiplier);
      den    = 64'd1;
      step   = 1'b0;
      case (mode)
         MODE_AUDIO:
            if (osc_cfg.mode_flags[FLAG_LOOP] && !osc_cfg.mode_flags[FLAG_OFFLINE]) begin
               step = 1'b1;
               num  = num * 64'(bs);
               den  = 64'(SEC_PER_MIN) * div * 64'(SAMPLE_RATE_DEF);
            end
         MODE_FRAME:
            if (osc_cfg.mode_flags[FLAG_OFFLINE]) begin
               step = 1'b1;
               den  = 64'(FRAME_DEN) * div;
            end
         MODE_RESET: begin
            x         = start_q32();
            osc_phase = x[FRAC_W-1:0];
            osc_shape = x[SHP_W-1:0];
         end
         MODE_READ: ;
      endcase

      if (step) begin
         // bounce runs at half speed so the triangle keeps the tempo
         if (bounce)
            den = den * 2;
         inc       = (num << FRAC_W) / den;
         osc_phase = osc_phase + inc[FRAC_W-1:0];
         x         = 64'(osc_phase);
         if (bounce)
            x = (x < UNIT_Q32 / 2) ? 2 * x : 2 * UNIT_Q32 - 2 * x;
         x = x + start_q32();
         if (x >= UNIT_Q32)
            x = x - UNIT_Q32;
         if (osc_cfg.quant_steps == 0)
            x = 64'd0;
         else if (osc_cfg.quant_steps != QUANT_OFF) begin
            k = (x * osc_cfg.quant_steps) >> FRAC_W;
            x = (k << FRAC_W) / osc_cfg.quant_steps;
         end
         osc_shape = x[SHP_W-1:0];
      end

      // downward mapping rounds the magnitude up so the value never passes high
      lo = 64'(osc_cfg.low_value);
      hi = 64'(osc_cfg.high_value);
      if (hi >= lo)
         mapped = lo + (((hi - lo) * osc_shape) >> FRAC_W);
      else
         mapped = lo - (((lo - hi) * osc_shape + UNIT_Q32 - 1) >> FRAC_W);
      res.mapped_value = mapped[Q16_W-1:0];
      res.raw_phase    = osc_phase[FRAC_W-1:Q16_FRAC];
      return res;
   endfunction

   // register value for a phase: lowest, highest, or random with the odd out-of-range one
   function automatic logic [CSR_DATA_W-1:0] reg_draw(input csr_idx_type idx,
                                                      input int phase);
      int lo, hi, top, v;
      case (idx)
         REG_TEMPO_BPM:       begin lo = 0; hi = 999;   top = 2**BPM_W - 1;   end
         REG_BEAT_DIVIDER:    begin lo = 1; hi = 64;    top = 2**DIV_W - 1;   end
         REG_BEAT_MULTIPLIER: begin lo = 1; hi = 12;    top = 2**MULT_W - 1;  end
         REG_QUANT_STEPS:     begin lo = 1; hi = 40;    top = 2**QUANT_W - 1; end
         REG_START_PHASE:     begin lo = 0; hi = 65536; top = 2**Q16_W - 1;   end
         REG_LOW_VALUE:       begin lo = 0; hi = 65536; top = 2**Q16_W - 1;   end
         REG_HIGH_VALUE:      begin lo = 0; hi = 65536; top = 2**Q16_W - 1;   end
         REG_MODE_FLAGS:      begin lo = 0; hi = 7;     top = 2**FLAGS_W - 1; end
      endcase
      if (phase == 0)
         return lo;
      if (phase == 1)
         return hi;
      case ($urandom_range(0, 5))
         0:       v = lo;
         1:       v = hi;
         2:       v = $urandom_range(0, top);
         default: v = $urandom_range(lo, hi);
      endcase
      // mostly looping, otherwise audio ticks would rarely move the phase
      if (idx == REG_MODE_FLAGS && $urandom_range(0, 3) != 0)
         v[FLAG_LOOP] = 1'b1;
      return v;
   endfunction

   function automatic void queue_tick(input mode_type mode, input int bs);
      tick_req_type t;
      t.mode        = mode;
      t.buffer_size = BS_W'(bs);
      queued_ticks.push_back(t);
   endfunction

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // wait until every queued tick has gone in and every response come back
   task automatic drain(input int settle);
      do @(negedge clock);
      while (queued_ticks.size() != 0 || req_valid || awaited_outputs.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // predictor follows every completed apb write
   always @(posedge clock) begin
      if (!reset && psel && penable && pwrite && pready)
         apply_register(csr_idx_type'(paddr[CSR_ADDR_W-1:2]), pwdata);
   end

   // request driver: predict on acceptance, then offer the next tick after its gap
   always @(posedge clock) begin
      tick_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_outputs.push_back(predict_tick(mode_type'(req_mode), req_buffer_size));
            ticks_sent++;
         end
         // a stalled request holds its payload
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (queued_ticks.size() != 0) begin
               nxt              = queued_ticks.pop_front();
               req_mode        <= nxt.mode;
               req_buffer_size <= nxt.buffer_size;
               req_valid       <= 1'b1;
               req_gap          = draw_wait(ticks_sent);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: compare against the oldest prediction, stall at random
   always @(posedge clock) begin
      osc_out_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            outputs_seen++;
            if (awaited_outputs.size() == 0) begin
               $error("response with no request pending: mapped_value %0d raw_phase %0d",
                      rsp_mapped_value, rsp_raw_phase);
               mismatch_seen = 1'b1;
            end else begin
               want = awaited_outputs.pop_front();
               if (rsp_mapped_value !== want.mapped_value) begin
                  $error("mapped_value: expected %0d, got %0d",
                         want.mapped_value, rsp_mapped_value);
                  mismatch_seen = 1'b1;
               end
               if (rsp_raw_phase !== want.raw_phase) begin
                  $error("raw_phase: expected %0d, got %0d", want.raw_phase, rsp_raw_phase);
                  mismatch_seen = 1'b1;
               end
            end
            rsp_hold = draw_wait(outputs_seen + BURST_LEN / 2);
         end else if (rsp_valid && rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   initial begin
      osc_cfg   = CFG_RESET;
      osc_phase = '0;
      osc_shape = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: every tick kind, smallest, largest and out-of-range buffers,
      // frame tick ignored while online
      queue_tick(MODE_READ, 1);
      queue_tick(MODE_AUDIO, 1);
      queue_tick(MODE_AUDIO, 8192);
      queue_tick(MODE_AUDIO, BS_TOP);
      queue_tick(MODE_FRAME, 100);
      queue_tick(MODE_RESET, 0);
      queue_tick(MODE_AUDIO, 0);
      drain(4);

      // offline bounce at full speed so each frame wraps past one; divider zero acts
      // as one, start phase above one saturates, quantisation zero flattens the shape,
      // and high below low maps downwards
      csr_write(REG_TEMPO_BPM, 999);
      csr_write(REG_BEAT_MULTIPLIER, 2**MULT_W - 1);
      csr_write(REG_BEAT_DIVIDER, 0);
      csr_write(REG_MODE_FLAGS, 7);
      csr_write(REG_START_PHASE, 2**Q16_W - 1);
      csr_write(REG_QUANT_STEPS, 0);
      csr_write(REG_LOW_VALUE, 65536);
      csr_write(REG_HIGH_VALUE, 0);
      @(negedge clock);
      queue_tick(MODE_FRAME, 1);
      queue_tick(MODE_FRAME, BS_TOP);
      queue_tick(MODE_AUDIO, 5000);
      queue_tick(MODE_RESET, 0);
      queue_tick(MODE_READ, 0);
      drain(4);

      // loop off: the flags write and then a start write both pin the shape;
      // quantisation above 40, slowest divider, no tempo, low at its field top
      csr_write(REG_MODE_FLAGS, 2);
      csr_write(REG_START_PHASE, 32768);
      csr_write(REG_QUANT_STEPS, 2**QUANT_W - 1);
      csr_write(REG_BEAT_DIVIDER, 2**DIV_W - 1);
      csr_write(REG_BEAT_MULTIPLIER, 0);
      csr_write(REG_TEMPO_BPM, 0);
      csr_write(REG_LOW_VALUE, 2**Q16_W - 1);
      csr_write(REG_HIGH_VALUE, 12345);
      @(negedge clock);
      queue_tick(MODE_AUDIO, 8192);
      queue_tick(MODE_FRAME, 1);
      queue_tick(MODE_READ, 0);
      queue_tick(MODE_RESET, 0);
      drain(4);

      // online bounce with big buffers wrapping the phase, start exactly one,
      // quantisation just above the off value
      csr_write(REG_MODE_FLAGS, 3);
      csr_write(REG_QUANT_STEPS, 41);
      csr_write(REG_TEMPO_BPM, 999);
      csr_write(REG_BEAT_MULTIPLIER, 12);
      csr_write(REG_BEAT_DIVIDER, 1);
      csr_write(REG_START_PHASE, 65536);
      csr_write(REG_LOW_VALUE, 0);
      csr_write(REG_HIGH_VALUE, 65536);
      @(negedge clock);
      queue_tick(MODE_AUDIO, BS_TOP);
      queue_tick(MODE_AUDIO, BS_TOP);
      queue_tick(MODE_AUDIO, BS_TOP);
      queue_tick(MODE_AUDIO, 0);
      queue_tick(MODE_RESET, 0);
      queue_tick(MODE_AUDIO, 4410);

      // random phases: first all lowest, then all highest, then mixed settings;
      // ticks mostly of the kind the current flags let advance
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain(4);
         for (int r = REG_TEMPO_BPM; r <= REG_MODE_FLAGS; r++)
            if (p < 2 || $urandom_range(0, 2) != 0)
               csr_write(csr_idx_type'(r), reg_draw(csr_idx_type'(r), p));
         @(negedge clock);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            int       r;
            mode_type m;
            r = $urandom_range(0, 19);
            if (r < 15)
               m = osc_cfg.mode_flags[FLAG_OFFLINE] ? MODE_FRAME : MODE_AUDIO;
            else if (r < 17)
               m = MODE_RESET;
            else if (r == 17)
               m = MODE_READ;
            else
               m = mode_type'($urandom_range(0, 3));
            queue_tick(m, ($urandom_range(0, 7) == 0) ? $urandom_range(0, BS_TOP)
                                                      : $urandom_range(1, 8192));
         end
      end

      drain(SETTLE_CYCLES);
      if (mismatch_seen)
         $display("Mismatches found");
      else
         $display("No mismatches found");
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
